/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* sv/hum_pkg.sv */
// ---------------------------------------------------------------------------
// hum_pkg
// shared types and constants of the two-wire humidity sensor master
// ---------------------------------------------------------------------------
`default_nettype none

package hum_pkg;

  localparam int TMO_CFG_W = 24;

  localparam logic [1:0] ACT_TEMP = 2'd1;
  localparam logic [1:0] ACT_HUMI = 2'd2;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_RESET_EN    = 2'd2;

  localparam logic [7:0]           HALF_PERIOD_RST = 8'd16;
  localparam logic [TMO_CFG_W-1:0] TIMEOUT_RST     = 24'hFF_FFFF;

  localparam logic [7:0] CMD_TEMP = 8'h03;
  localparam logic [7:0] CMD_HUMI = 8'h05;

  localparam logic [3:0] RST_CLOCKS = 4'd9;
  localparam logic [3:0] START_LEN  = 4'd7;
  localparam logic [3:0] BYTE_BITS  = 4'd8;
  localparam logic [1:0] READ_BYTES = 2'd3;

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00_0000_0000_0001,
    PH_RST_HI  = 14'b00_0000_0000_0010,
    PH_RST_LO  = 14'b00_0000_0000_0100,
    PH_START   = 14'b00_0000_0000_1000,
    PH_WR_LO   = 14'b00_0000_0001_0000,
    PH_WR_HI   = 14'b00_0000_0010_0000,
    PH_ACK_LO  = 14'b00_0000_0100_0000,
    PH_ACK_HI  = 14'b00_0000_1000_0000,
    PH_WAIT    = 14'b00_0001_0000_0000,
    PH_RD_HI   = 14'b00_0010_0000_0000,
    PH_RD_LO   = 14'b00_0100_0000_0000,
    PH_RACK_LO = 14'b00_1000_0000_0000,
    PH_RACK_HI = 14'b01_0000_0000_0000,
    PH_DONE    = 14'b10_0000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]           half_period;
    logic [TMO_CFG_W-1:0] timeout;
    logic                 reset_en;
  } cfg_t;

  typedef struct packed {
    logic        scl;
    logic        sda_release;
    logic        busy;
    logic        done;
    logic [1:0]  errors;
    logic [15:0] value;
    logic [7:0]  check;
  } res_t;

  // transmission-start pattern, clock and data per slot
  function automatic logic [1:0] start_pattern(input logic [3:0] idx);
    logic [1:0] sc_sd;
    case (idx)
      4'd0:    sc_sd = 2'b01;
      4'd1:    sc_sd = 2'b11;
      4'd2:    sc_sd = 2'b10;
      4'd3:    sc_sd = 2'b00;
      4'd4:    sc_sd = 2'b10;
      4'd5:    sc_sd = 2'b11;
      4'd6:    sc_sd = 2'b01;
      default: sc_sd = 2'b01;
    endcase
    return sc_sd;
  endfunction

endpackage

`default_nettype wire

/* sv/humidity_sensor_two_wire_master.sv */
// a tick's line levels and status are registered into the output register, or into the skid entry while it is stalled
// throughput: one tick per cycle while in_stall is low; the sequencer state advances once per transaction
// an output register plus one skid entry: input stalls only once both hold a waiting result
// reset (rst_n low, synchronous): sequencer idle, counters and captured data zero,
// registers back to half period 16, timeout 16777215, connection reset enabled
// ---------------------------------------------------------------------------
// humidity_sensor_two_wire_master
// measurement sequence master for a two-wire humidity and temperature sensor
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module humidity_sensor_two_wire_master import hum_pkg::*; #(
  parameter int TIMEOUT_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [TMO_CFG_W-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic                 in_sda_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scl_out,
  output logic                      out_sda_release,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic [1:0]                out_error_count,
  output logic [15:0]               out_measure_value,
  output logic [7:0]                out_check_byte
);

  cfg_t cfg_r;
  res_t res_now;
  res_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;
  logic in_acc, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= HALF_PERIOD_RST;
      cfg_r.timeout     <= TIMEOUT_RST;
      cfg_r.reset_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: cfg_r.half_period <= cfg_wdata[7:0];
        CFG_TIMEOUT:     cfg_r.timeout     <= cfg_wdata;
        CFG_RESET_EN:    cfg_r.reset_en    <= cfg_wdata[0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = main_valid_r && !out_stall;

  hum_seq #(
    .TIMEOUT_BITS(TIMEOUT_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_acc),
    .action (in_action),
    .sda    (in_sda_in),
    .cfg    (cfg_r),
    .res    (res_now)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!main_valid_r || out_take) begin
        if (skid_valid_r) begin
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_take) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (in_acc) begin
        main_r <= res_now;
      end
    end else if (in_acc) begin
      skid_r <= res_now;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_scl_out       = main_r.scl;
  assign out_sda_release   = main_r.sda_release;
  assign out_busy_res      = main_r.busy;
  assign out_done_res      = main_r.done;
  assign out_error_count   = main_r.errors;
  assign out_measure_value = main_r.value;
  assign out_check_byte    = main_r.check;

  `ASSERT_NEVER(a_skid_needs_main, clk, rst_n, skid_valid_r && !main_valid_r,
                "skid entry without output entry")
  `ASSERT_AT(a_done_not_busy, clk, rst_n, out_valid && out_done_res |-> !out_busy_res,
             "done while busy")
  `ASSERT_AT(a_idle_clean, clk, rst_n,
             out_valid && !out_done_res |-> out_error_count == 2'd0 &&
               out_measure_value == 16'd0 && out_check_byte == 8'd0,
             "result fields set without done")
  `ASSERT_AT(a_skid_holds_input, clk, rst_n, skid_valid_r && out_stall |=> skid_valid_r,
             "skid entry lost while stalled")

endmodule

`default_nettype wire

/* sv/hum_seq.sv */
// ---------------------------------------------------------------------------
// hum_seq
// bit-level measurement sequencer, one step per accepted tick
// ---------------------------------------------------------------------------
`default_nettype none

module hum_seq import hum_pkg::*; #(
  parameter int TIMEOUT_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [1:0] action,
  input  wire logic       sda,
  input  wire cfg_t       cfg,
  output res_t            res
);

  localparam int LW = (TIMEOUT_BITS > TMO_CFG_W) ? TIMEOUT_BITS : TMO_CFG_W;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              tdiv_r, tdiv_nxt;
  logic [3:0]              bit_cnt_r, bit_cnt_nxt;
  logic [1:0]              byte_cnt_r, byte_cnt_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [15:0]             data_r, data_nxt;
  logic [7:0]              check_r, check_nxt;
  logic [TIMEOUT_BITS-1:0] wait_r, wait_nxt;
  logic [1:0]              err_r, err_nxt;
  logic [7:0]              cmd_r, cmd_nxt;

  logic [7:0]              half;
  logic [8:0]              tdiv_inc;
  logic                    slot_end;
  logic [7:0]              tdiv_step;
  logic [TIMEOUT_BITS-1:0] wait_inc;
  logic [LW-1:0]           mask_ext, tmo_ext, lim_cut, lim;
  logic                    timed_out;
  logic [3:0]              bit_inc;
  logic [1:0]              byte_inc;
  logic [1:0]              start_sc_sd;
  logic                    start_req;

  assign half      = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
  assign tdiv_inc  = {1'b0, tdiv_r} + 9'd1;
  assign slot_end  = (tdiv_inc >= {1'b0, half});
  assign tdiv_step = slot_end ? 8'd0 : tdiv_inc[7:0];

  assign wait_inc  = (&wait_r) ? wait_r : wait_r + TIMEOUT_BITS'(1);
  assign mask_ext  = LW'({TIMEOUT_BITS{1'b1}});
  assign tmo_ext   = LW'(cfg.timeout);
  assign lim_cut   = (tmo_ext > mask_ext) ? mask_ext : tmo_ext;
  assign lim       = (lim_cut == '0) ? LW'(1) : lim_cut;
  assign timed_out = (LW'(wait_inc) >= lim);

  assign bit_inc     = bit_cnt_r + 4'd1;
  assign byte_inc    = byte_cnt_r + 2'd1;
  assign start_sc_sd = start_pattern(bit_cnt_r);
  assign start_req   = (action == ACT_TEMP) || (action == ACT_HUMI);

  // line levels and status from the current state
  always_comb begin
    res = '0;
    res.sda_release = 1'b1;
    res.busy = 1'b1;
    case (phase_r)
      PH_IDLE: begin
        res.busy = 1'b0;
      end
      PH_DONE: begin
        res.busy   = 1'b0;
        res.done   = 1'b1;
        res.errors = err_r;
        res.value  = data_r;
        res.check  = check_r;
      end
      PH_RST_HI, PH_ACK_HI, PH_RD_HI: begin
        res.scl = 1'b1;
      end
      PH_START: begin
        res.scl         = start_sc_sd[1];
        res.sda_release = start_sc_sd[0];
      end
      PH_WR_LO: begin
        res.sda_release = shift_r[7];
      end
      PH_WR_HI: begin
        res.scl         = 1'b1;
        res.sda_release = shift_r[7];
      end
      PH_RACK_LO: begin
        res.sda_release = (byte_cnt_r >= 2'd2);
      end
      PH_RACK_HI: begin
        res.scl         = 1'b1;
        res.sda_release = (byte_cnt_r >= 2'd2);
      end
      default: begin
        res.busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    tdiv_nxt     = tdiv_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    data_nxt     = data_r;
    check_nxt    = check_r;
    wait_nxt     = wait_r;
    err_nxt      = err_r;
    cmd_nxt      = cmd_r;
    case (phase_r)
      PH_IDLE, PH_DONE: begin
        phase_nxt = PH_IDLE;
        if (start_req) begin
          cmd_nxt      = (action == ACT_TEMP) ? CMD_TEMP : CMD_HUMI;
          err_nxt      = 2'd0;
          tdiv_nxt     = 8'd0;
          bit_cnt_nxt  = 4'd0;
          byte_cnt_nxt = 2'd0;
          shift_nxt    = 8'd0;
          wait_nxt     = '0;
          phase_nxt    = cfg.reset_en ? PH_RST_HI : PH_START;
        end
      end
      PH_RST_HI: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) phase_nxt = PH_RST_LO;
      end
      PH_RST_LO: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          if (bit_inc >= RST_CLOCKS) begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_START;
          end else begin
            bit_cnt_nxt = bit_inc;
            phase_nxt   = PH_RST_HI;
          end
        end
      end
      PH_START: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          if (bit_inc >= START_LEN) begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = cmd_r;
            phase_nxt   = PH_WR_LO;
          end else begin
            bit_cnt_nxt = bit_inc;
          end
        end
      end
      PH_WR_LO: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) phase_nxt = PH_WR_HI;
      end
      PH_WR_HI: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= BYTE_BITS) ? PH_ACK_LO : PH_WR_LO;
        end
      end
      PH_ACK_LO: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) phase_nxt = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          if (sda) err_nxt = err_r + 2'd1;
          wait_nxt  = '0;
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!sda || timed_out) begin
          if (sda) begin
            wait_nxt = wait_inc;
            err_nxt  = err_r + 2'd1;
          end
          phase_nxt    = PH_RD_HI;
          tdiv_nxt     = 8'd0;
          bit_cnt_nxt  = 4'd0;
          byte_cnt_nxt = 2'd0;
          shift_nxt    = 8'd0;
        end else begin
          wait_nxt = wait_inc;
        end
      end
      PH_RD_HI: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          shift_nxt = {shift_r[6:0], sda};
          phase_nxt = PH_RD_LO;
        end
      end
      PH_RD_LO: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          bit_cnt_nxt = bit_inc;
          if (bit_inc >= BYTE_BITS) begin
            if (byte_cnt_r == 2'd0) begin
              data_nxt = {shift_r, 8'd0};
            end else if (byte_cnt_r == 2'd1) begin
              data_nxt = {data_r[15:8], shift_r};
            end else begin
              check_nxt = shift_r;
            end
            phase_nxt = PH_RACK_LO;
          end else begin
            phase_nxt = PH_RD_HI;
          end
        end
      end
      PH_RACK_LO: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) phase_nxt = PH_RACK_HI;
      end
      PH_RACK_HI: begin
        tdiv_nxt = tdiv_step;
        if (slot_end) begin
          if (byte_inc >= READ_BYTES) begin
            byte_cnt_nxt = 2'd0;
            phase_nxt    = PH_DONE;
          end else begin
            byte_cnt_nxt = byte_inc;
            bit_cnt_nxt  = 4'd0;
            shift_nxt    = 8'd0;
            phase_nxt    = PH_RD_HI;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tdiv_r     <= 8'd0;
      bit_cnt_r  <= 4'd0;
      byte_cnt_r <= 2'd0;
      shift_r    <= 8'd0;
      data_r     <= 16'd0;
      check_r    <= 8'd0;
      wait_r     <= '0;
      err_r      <= 2'd0;
      cmd_r      <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tdiv_r     <= tdiv_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      data_r     <= data_nxt;
      check_r    <= check_nxt;
      wait_r     <= wait_nxt;
      err_r      <= err_nxt;
      cmd_r      <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the two-wire humidity sensor master. Ticks carry start
// requests and a data line level that acts like a sensor: it mostly acks and
// signals ready, and sometimes stays high until the ready timeout runs out.
// A cycle-level predictor of the sequencer is run on each accepted tick. Its
// line levels, status and read data are compared with each result
// transaction, under several register settings and idle and stall patterns.
// ---------------------------------------------------------------------------
module tb_top import hum_pkg::*;;

  localparam logic [1:0]  ACT_TICK   = 2'd0;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam int unsigned PAUSE_AT    = 50;
  localparam int unsigned DRAIN_LIMIT = 10000;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_DST_STALL, FLOW_BOTH} flow_t;

  class hum_scoreboard;
    logic [7:0]  half_cfg;
    logic [23:0] tmo_cfg;
    logic        rst_en_cfg;
    phase_t      ph;
    logic [7:0]  tick_div;
    logic [3:0]  bit_cnt;
    logic [1:0]  byte_cnt;
    logic [7:0]  shreg;
    logic [15:0] word;
    logic [7:0]  chk;
    logic [23:0] wait_cnt;
    logic [1:0]  errs;
    logic [7:0]  cmd;
    res_t        line_q[$];
    int unsigned mismatches, ticks, starts, dones, err_runs, timeouts;

    function new();
      half_cfg = HALF_PERIOD_RST;
      tmo_cfg = TIMEOUT_RST;
      rst_en_cfg = 1'b1;
      ph = PH_IDLE;
      tick_div = '0;
      bit_cnt = '0;
      byte_cnt = '0;
      shreg = '0;
      word = '0;
      chk = '0;
      wait_cnt = '0;
      errs = '0;
      cmd = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_HALF_PERIOD: half_cfg = val[7:0];
        CFG_TIMEOUT:     tmo_cfg = val;
        CFG_RESET_EN:    rst_en_cfg = val[0];
        default: ;
      endcase
    endfunction

    function phase_t phase_now();
      return ph;
    endfunction

    function int unsigned pending();
      return line_q.size();
    endfunction

    function bit slot_end();
      int unsigned h;
      h = (half_cfg == 0) ? 1 : half_cfg;
      if (tick_div + 1 >= h) begin
        tick_div = '0;
        return 1'b1;
      end
      tick_div++;
      return 1'b0;
    endfunction

    // predict the line levels of this tick, then advance the sequencer
    function void note(logic [1:0] act, logic sda);
      localparam logic [6:0] START_SCL = 7'b0110110;
      localparam logic [6:0] START_SDA = 7'b1100011;
      res_t        r;
      logic [23:0] lim;
      bit          go;
      r = '0;
      r.sda_release = 1'b1;
      r.busy = 1'b1;
      case (ph)
        PH_RST_HI, PH_ACK_HI, PH_RD_HI: r.scl = 1'b1;
        PH_START: begin
          r.scl = START_SCL[bit_cnt[2:0]];
          r.sda_release = START_SDA[bit_cnt[2:0]];
        end
        PH_WR_LO: r.sda_release = shreg[7];
        PH_WR_HI: begin
          r.scl = 1'b1;
          r.sda_release = shreg[7];
        end
        PH_RACK_LO: r.sda_release = (byte_cnt >= 2);
        PH_RACK_HI: begin
          r.scl = 1'b1;
          r.sda_release = (byte_cnt >= 2);
        end
        PH_IDLE: r.busy = 1'b0;
        PH_DONE: begin
          r.busy = 1'b0;
          r.done = 1'b1;
          r.errors = errs;
          r.value = word;
          r.check = chk;
        end
        default: ;
      endcase
      line_q.push_back(r);
      ticks++;

      case (ph)
        PH_IDLE, PH_DONE: begin
          ph = PH_IDLE;
          if (act == ACT_TEMP || act == ACT_HUMI) begin
            cmd = (act == ACT_TEMP) ? CMD_TEMP : CMD_HUMI;
            errs = '0;
            tick_div = '0;
            bit_cnt = '0;
            byte_cnt = '0;
            shreg = '0;
            wait_cnt = '0;
            ph = rst_en_cfg ? PH_RST_HI : PH_START;
            starts++;
          end
        end
        PH_RST_HI: if (slot_end()) ph = PH_RST_LO;
        PH_RST_LO: if (slot_end()) begin
          bit_cnt++;
          if (bit_cnt >= RST_CLOCKS) begin
            bit_cnt = '0;
            ph = PH_START;
          end else begin
            ph = PH_RST_HI;
          end
        end
        PH_START: if (slot_end()) begin
          bit_cnt++;
          if (bit_cnt >= START_LEN) begin
            bit_cnt = '0;
            shreg = cmd;
            ph = PH_WR_LO;
          end
        end
        PH_WR_LO: if (slot_end()) ph = PH_WR_HI;
        PH_WR_HI: if (slot_end()) begin
          shreg = shreg << 1;
          bit_cnt++;
          ph = (bit_cnt >= BYTE_BITS) ? PH_ACK_LO : PH_WR_LO;
        end
        PH_ACK_LO: if (slot_end()) ph = PH_ACK_HI;
        PH_ACK_HI: if (slot_end()) begin
          if (sda) errs++;
          wait_cnt = '0;
          ph = PH_WAIT;
        end
        PH_WAIT: begin
          lim = (tmo_cfg == 0) ? 24'd1 : tmo_cfg;
          go = 1'b0;
          if (!sda) begin
            go = 1'b1;
          end else begin
            if (wait_cnt != '1) wait_cnt++;
            if (wait_cnt >= lim) begin
              errs++;
              timeouts++;
              go = 1'b1;
            end
          end
          if (go) begin
            ph = PH_RD_HI;
            tick_div = '0;
            bit_cnt = '0;
            byte_cnt = '0;
            shreg = '0;
          end
        end
        PH_RD_HI: if (slot_end()) begin
          shreg = {shreg[6:0], sda};
          ph = PH_RD_LO;
        end
        PH_RD_LO: if (slot_end()) begin
          bit_cnt++;
          if (bit_cnt >= BYTE_BITS) begin
            if (byte_cnt == 0) word = {shreg, 8'h00};
            else if (byte_cnt == 1) word[7:0] = shreg;
            else chk = shreg;
            ph = PH_RACK_LO;
          end else begin
            ph = PH_RD_HI;
          end
        end
        PH_RACK_LO: if (slot_end()) ph = PH_RACK_HI;
        PH_RACK_HI: if (slot_end()) begin
          byte_cnt++;
          if (byte_cnt >= READ_BYTES) begin
            byte_cnt = '0;
            ph = PH_DONE;
            dones++;
            if (errs != 0) err_runs++;
          end else begin
            bit_cnt = '0;
            shreg = '0;
            ph = PH_RD_HI;
          end
        end
        default: ph = PH_IDLE;
      endcase
    endfunction

    function void cmp(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      end
    endfunction

    function void check(res_t got);
      res_t want;
      if (line_q.size() == 0) begin
        mismatches++;
        $error("result transaction with no pending expectation");
        return;
      end
      want = line_q.pop_front();
      cmp("scl_out", want.scl, got.scl);
      cmp("sda_release", want.sda_release, got.sda_release);
      cmp("busy_res", want.busy, got.busy);
      cmp("done_res", want.done, got.done);
      cmp("error_count", want.errors, got.errors);
      cmp("measure_value", want.value, got.value);
      cmp("check_byte", want.check, got.check);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [TMO_CFG_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action = ACT_TICK;
  logic                 in_sda_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_scl_out;
  logic                 out_sda_release;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [1:0]           out_error_count;
  logic [15:0]          out_measure_value;
  logic [7:0]           out_check_byte;

  hum_scoreboard sb = new();
  flow_t         flow_mode = FLOW_FREE;
  int unsigned   settings = 0;

  humidity_sensor_two_wire_master dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check({out_scl_out, out_sda_release, out_busy_res, out_done_res,
                out_error_count, out_measure_value, out_check_byte});
    case (flow_mode)
      FLOW_DST_STALL: out_stall <= ($urandom_range(0, 99) < 76);
      FLOW_BOTH:      out_stall <= ($urandom_range(0, 99) < 17);
      default:        out_stall <= 1'b0;
    endcase
  end

  function automatic bit sender_idles();
    case (flow_mode)
      FLOW_SRC_IDLE: return $urandom_range(0, 99) < 76;
      FLOW_BOTH:     return $urandom_range(0, 99) < 17;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic send_tick(logic [1:0] act, logic sda);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sda_in <= sda;
    do @(posedge clk); while (in_stall);
    sb.note(act, sda);
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] h, logic [23:0] tmo, logic ren);
    logic [23:0] hv, rv;
    hv = {16'($urandom), h};
    rv = {23'($urandom), ren};
    cfg_we <= 1'b1;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_wdata <= hv;
    @(posedge clk);
    sb.set_reg(CFG_HALF_PERIOD, hv);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    sb.set_reg(CFG_TIMEOUT, tmo);
    cfg_index <= CFG_RESET_EN;
    cfg_wdata <= rv;
    @(posedge clk);
    sb.set_reg(CFG_RESET_EN, rv);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(logic [7:0] h, logic [23:0] tmo, logic ren, flow_t f,
                           int unsigned min_items, int unsigned min_dones,
                           int unsigned cap);
    int unsigned n, d0;
    logic [1:0]  act;
    logic        sda;
    logic        stuck;
    n = 0;
    stuck = 1'b0;
    drain();
    write_regs(h, tmo, ren);
    flow_mode = f;
    d0 = sb.dones;
    while ((n < min_items || sb.dones - d0 < min_dones) && n < cap) begin
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        drain();
      end
      case (sb.phase_now())
        PH_IDLE, PH_DONE: begin
          if ($urandom_range(0, 3) == 0) act = 2'($urandom_range(0, 3));
          else act = $urandom_range(0, 1) ? ACT_TEMP : ACT_HUMI;
          stuck = (tmo <= 200) && ($urandom_range(0, 3) == 0);
        end
        default: act = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : ACT_TICK;
      endcase
      case (sb.phase_now())
        PH_ACK_LO, PH_ACK_HI: sda = ($urandom_range(0, 5) == 0);
        PH_WAIT:              sda = stuck || ($urandom_range(0, 2) != 0);
        default:              sda = 1'($urandom_range(0, 1));
      endcase
      send_tick(act, sda);
      n++;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle ticks, unused action, start, starts while busy
    send_tick(ACT_TICK, 1'b0);
    send_tick(ACT_UNUSED, 1'b1);
    send_tick(ACT_TICK, 1'b1);
    send_tick(ACT_UNUSED, 1'b0);
    send_tick(ACT_TEMP, 1'b1);
    send_tick(ACT_HUMI, 1'b0);
    send_tick(ACT_UNUSED, 1'b0);
    send_tick(ACT_TEMP, 1'b1);
    repeat (6) send_tick(ACT_TICK, 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    run_phase(8'd1,   24'd3,        1'b0, FLOW_FREE,      130, 1, 900);
    run_phase(8'd0,   24'd0,        1'b1, FLOW_SRC_IDLE,  130, 1, 900);
    run_phase(8'd2,   24'hFF_FFFF,  1'b0, FLOW_DST_STALL, 130, 1, 900);
    run_phase(8'd1,   24'd1,        1'b1, FLOW_BOTH,      130, 1, 900);
    run_phase(8'd255, 24'd5,        1'b1, FLOW_FREE,      200, 0, 200);
    run_phase(8'd1,   24'd20,       1'b0, FLOW_SRC_IDLE,  130, 1, 900);
    run_phase(8'd1, 24'($urandom_range(1, 60)), 1'($urandom_range(0, 1)),
              FLOW_DST_STALL, 130, 1, 900);
    run_phase(8'd0,   24'd2,        1'b0, FLOW_BOTH,      130, 1, 900);
    drain();

    $display("covered %0d ticks under %0d register settings, %0d measurements started",
             sb.ticks, settings, sb.starts);
    $display("%0d measurements completed, %0d with ack or ready errors, %0d ready timeouts",
             sb.dones, sb.err_runs, sb.timeouts);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** humidity_sensor_two_wire_master: PASSED **");
    else
      $display("** humidity_sensor_two_wire_master: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** humidity_sensor_two_wire_master: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/hum_pkg.sv
sv/hum_seq.sv
sv/humidity_sensor_two_wire_master.sv
verif/tb_top.sv
